>>> rtl/r2sa_pkg.sv
// Package for the weighted R-squared split scorer: item types, register codes and state codes.
package r2sa_pkg;

	localparam int MAX_TARGETS    = 4;
	localparam int MAX_CANDIDATES = 65536;
	localparam int CAND_W         = $clog2(MAX_CANDIDATES);
	localparam int TIX_W          = 2;
	localparam int VAL_W          = 48;
	localparam int WSUM_W         = 40;
	localparam int CNT_W          = 24;
	localparam int SPREAD_W       = 47;
	localparam int SCORE_W        = 32;
	localparam int CFG_IDX_W      = 3;
	localparam int CFG_DATA_W     = 47;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_SUM   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_SIDE     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TGT_SPREAD_0 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_TGT_SPREAD_1 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_TGT_SPREAD_2 = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_TGT_SPREAD_3 = 3'd5;

	typedef struct packed {
		logic signed [VAL_W-1:0] pred_sum;
		logic signed [VAL_W-1:0] pred_square_sum;
		logic signed [VAL_W-1:0] cross_sum;
		logic [TIX_W-1:0]        target_index;
		logic [CNT_W-1:0]        left_count;
		logic [CNT_W-1:0]        right_count;
		logic                    last_target;
		logic                    last_candidate;
	} in_item_t;

	typedef struct packed {
		logic [SCORE_W-1:0] score;
		logic [CAND_W-1:0]  candidate_index;
		logic [CAND_W-1:0]  best_index;
		logic               scan_done;
	} out_item_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL_A,
		ST_MUL_B,
		ST_VAR,
		ST_MUL_C,
		ST_MUL_N,
		ST_MUL_D,
		ST_SAT,
		ST_DIV,
		ST_ACC,
		ST_DONE
	} state_t;

	// Magnitude of a two's complement value; the most negative value maps to 2^47.
	function automatic logic [VAL_W-1:0] mag48(input logic [VAL_W-1:0] v);
		return v[VAL_W-1] ? (~v + {{(VAL_W-1){1'b0}}, 1'b1}) : v;
	endfunction

endpackage

>>> rtl/r_squared_split_argmax_top.sv
// Weighted R-squared split scorer with running argmax, built on a bit-serial multiplier.
//
//  Channel | Signals                          | Moves
//  in      | in_valid, in_ready, in_data      | one target item of a candidate
//  out     | out_valid, out_ready, out_data   | score and argmax of a closed candidate
//  cfg     | cfg_valid, cfg_ready, cfg_index, | one register write
//          | cfg_data                         |
//
// The time from one acceptance to the next is set by the shift-add multiplier (one multiplier
// bit a cycle, five products) and the 32-step restoring divider; the division is skipped when
// the term saturates, and the products after the variance are skipped when the variance or the
// target spread is zero. Items are taken one at a time.
// Reset clears the control state, the counters and the configuration registers to their reset values.
// A stalled output holds its item; the next item is still taken and worked on, and only
// its closing step waits for the output register to free up.
module r_squared_split_argmax_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  r2sa_pkg::in_item_t                   in_data,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output r2sa_pkg::out_item_t                  out_data,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [r2sa_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [r2sa_pkg::CFG_DATA_W-1:0]      cfg_data
);

	localparam int P_W   = 144;
	localparam int Q_W   = 48;
	localparam int AB_W  = 96;
	localparam int VAR_W = 97;
	localparam int NUM_W = 172;
	localparam int DEN_W = 144;
	localparam int DVS_W = 175;

	r2sa_pkg::state_t state_q, state_d;

	// Configuration registers.
	logic [r2sa_pkg::WSUM_W-1:0]   wsum_q;
	logic [r2sa_pkg::CNT_W-1:0]    min_side_q;
	logic [r2sa_pkg::SPREAD_W-1:0] spread_q [r2sa_pkg::MAX_TARGETS];

	// Fields of the item at work.
	logic [r2sa_pkg::VAL_W-1:0]    m1_q, mc_q;
	logic                          s2neg_q;
	logic [r2sa_pkg::SPREAD_W-1:0] syy_q;
	logic                          tix_ok_q;
	logic [r2sa_pkg::CNT_W-1:0]    lc_q, rc_q;
	logic                          last_t_q, last_c_q;

	// Shared shift-add multiplier.
	logic [P_W-1:0] p_q, m_q, p_next;
	logic [Q_W-1:0] q_q;
	logic [5:0]     cnt_q;

	logic [AB_W-1:0]  a_q, b_q;
	logic [VAR_W-1:0] var_q, var_d;
	logic             varneg_q, varneg_d;
	logic [NUM_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [DVS_W-1:0] dvs_q;
	logic [r2sa_pkg::SCORE_W-1:0] quo_q;

	// Score state.
	logic [r2sa_pkg::SCORE_W-1:0] acc_q, best_score_q;
	logic [r2sa_pkg::CAND_W-1:0]  cand_q, best_cand_q;

	logic                         out_valid_q;
	r2sa_pkg::out_item_t          out_q;

	logic                         in_fire, out_load, cnt_end, sat_hit, div_take;
	logic [r2sa_pkg::SCORE_W:0]   acc_sum;
	logic [r2sa_pkg::SCORE_W-1:0] score_d;

	assign in_fire  = in_valid && in_ready;
	assign cnt_end  = (cnt_q == 6'd0);
	assign p_next   = q_q[0] ? (p_q + m_q) : p_q;
	assign sat_hit  = ({4'b0, rem_q} >= {den_q, 32'b0});
	assign div_take = ({3'b0, rem_q} >= dvs_q);
	assign acc_sum  = {1'b0, acc_q} + {1'b0, quo_q};
	assign score_d  = (lc_q < min_side_q || rc_q < min_side_q) ? '0 : acc_q;

	// Signed variance from the two products.
	always_comb begin
		if (s2neg_q) begin
			var_d    = {1'b0, a_q} + {1'b0, b_q};
			varneg_d = 1'b1;
		end else if (a_q >= b_q) begin
			var_d    = {1'b0, a_q - b_q};
			varneg_d = 1'b0;
		end else begin
			var_d    = {1'b0, b_q - a_q};
			varneg_d = 1'b1;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			r2sa_pkg::ST_IDLE:  if (in_fire) state_d = r2sa_pkg::ST_MUL_A;
			r2sa_pkg::ST_MUL_A: if (cnt_end) state_d = r2sa_pkg::ST_MUL_B;
			r2sa_pkg::ST_MUL_B: if (cnt_end) state_d = r2sa_pkg::ST_VAR;
			r2sa_pkg::ST_VAR: begin
				if (var_d == '0 || syy_q == '0 || !tix_ok_q) state_d = r2sa_pkg::ST_DONE;
				else state_d = r2sa_pkg::ST_MUL_C;
			end
			r2sa_pkg::ST_MUL_C: if (cnt_end) state_d = r2sa_pkg::ST_MUL_N;
			r2sa_pkg::ST_MUL_N: if (cnt_end) state_d = r2sa_pkg::ST_MUL_D;
			r2sa_pkg::ST_MUL_D: if (cnt_end) state_d = r2sa_pkg::ST_SAT;
			r2sa_pkg::ST_SAT: begin
				if (sat_hit) state_d = r2sa_pkg::ST_ACC;
				else state_d = r2sa_pkg::ST_DIV;
			end
			r2sa_pkg::ST_DIV:   if (cnt_end) state_d = r2sa_pkg::ST_ACC;
			r2sa_pkg::ST_ACC:   state_d = r2sa_pkg::ST_DONE;
			r2sa_pkg::ST_DONE: begin
				if (!last_t_q || out_load) state_d = r2sa_pkg::ST_IDLE;
			end
			default:            state_d = r2sa_pkg::ST_IDLE;
		endcase
	end

	// Handshake outputs.
	always_comb begin
		in_ready  = (state_q == r2sa_pkg::ST_IDLE);
		cfg_ready = 1'b1;
		out_load  = (state_q == r2sa_pkg::ST_DONE) && last_t_q
		            && (!out_valid_q || out_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= r2sa_pkg::ST_IDLE;
		else state_q <= state_d;
	end

	// Configuration writes; indexes beyond the list are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wsum_q     <= '0;
			min_side_q <= r2sa_pkg::CNT_W'(1);
			for (int i = 0; i < r2sa_pkg::MAX_TARGETS; i++) spread_q[i] <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				r2sa_pkg::CFG_WEIGHT_SUM:   wsum_q      <= cfg_data[r2sa_pkg::WSUM_W-1:0];
				r2sa_pkg::CFG_MIN_SIDE:     min_side_q  <= cfg_data[r2sa_pkg::CNT_W-1:0];
				r2sa_pkg::CFG_TGT_SPREAD_0: spread_q[0] <= cfg_data;
				r2sa_pkg::CFG_TGT_SPREAD_1: spread_q[1] <= cfg_data;
				r2sa_pkg::CFG_TGT_SPREAD_2: spread_q[2] <= cfg_data;
				r2sa_pkg::CFG_TGT_SPREAD_3: spread_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	// Datapath: operand capture, serial products, variance and restoring division.
	always_ff @(posedge clk) begin
		case (state_q)
			r2sa_pkg::ST_IDLE: begin
				if (in_fire) begin
					m1_q     <= r2sa_pkg::mag48(in_data.pred_sum);
					mc_q     <= r2sa_pkg::mag48(in_data.cross_sum);
					s2neg_q  <= in_data.pred_square_sum[r2sa_pkg::VAL_W-1];
					syy_q    <= spread_q[in_data.target_index];
					tix_ok_q <= ({1'b0, in_data.target_index} < 3'(r2sa_pkg::MAX_TARGETS));
					lc_q     <= in_data.left_count;
					rc_q     <= in_data.right_count;
					last_t_q <= in_data.last_target;
					last_c_q <= in_data.last_candidate;
					p_q      <= '0;
					m_q      <= P_W'(wsum_q);
					q_q      <= r2sa_pkg::mag48(in_data.pred_square_sum);
					cnt_q    <= 6'd47;
				end
			end
			r2sa_pkg::ST_MUL_A, r2sa_pkg::ST_MUL_B, r2sa_pkg::ST_MUL_C,
			r2sa_pkg::ST_MUL_N, r2sa_pkg::ST_MUL_D: begin
				p_q   <= p_next;
				m_q   <= {m_q[P_W-2:0], 1'b0};
				q_q   <= {1'b0, q_q[Q_W-1:1]};
				cnt_q <= cnt_q - 6'd1;
				if (cnt_end) begin
					p_q <= '0;
					case (state_q)
						r2sa_pkg::ST_MUL_A: begin
							a_q   <= {p_next[87:0], 8'b0};
							m_q   <= P_W'(m1_q);
							q_q   <= m1_q;
							cnt_q <= 6'd47;
						end
						r2sa_pkg::ST_MUL_B: b_q <= p_next[AB_W-1:0];
						r2sa_pkg::ST_MUL_C: begin
							m_q   <= P_W'(p_next[AB_W-1:0]);
							q_q   <= Q_W'(wsum_q);
							cnt_q <= 6'd39;
						end
						r2sa_pkg::ST_MUL_N: begin
							rem_q <= {p_next[135:0], 36'b0};
							m_q   <= P_W'(var_q);
							q_q   <= Q_W'(syy_q);
							cnt_q <= 6'd46;
						end
						default: den_q <= p_next;
					endcase
				end
			end
			r2sa_pkg::ST_VAR: begin
				var_q    <= var_d;
				varneg_q <= varneg_d;
				p_q      <= '0;
				m_q      <= P_W'(mc_q);
				q_q      <= mc_q;
				cnt_q    <= 6'd47;
			end
			r2sa_pkg::ST_SAT: begin
				quo_q <= '1;
				dvs_q <= {den_q, 31'b0};
				cnt_q <= 6'd31;
			end
			r2sa_pkg::ST_DIV: begin
				if (div_take) rem_q <= rem_q - dvs_q[NUM_W-1:0];
				quo_q <= {quo_q[r2sa_pkg::SCORE_W-2:0], div_take};
				dvs_q <= {1'b0, dvs_q[DVS_W-1:1]};
				cnt_q <= cnt_q - 6'd1;
			end
			default: ;
		endcase
	end

	// Score accumulation, argmax and candidate counting.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q        <= '0;
			best_score_q <= '0;
			cand_q       <= '0;
			best_cand_q  <= '0;
		end else if (state_q == r2sa_pkg::ST_ACC) begin
			if (!varneg_q) acc_q <= acc_sum[r2sa_pkg::SCORE_W] ? '1 : acc_sum[r2sa_pkg::SCORE_W-1:0];
			else acc_q <= (acc_q > quo_q) ? (acc_q - quo_q) : '0;
		end else if (out_load) begin
			acc_q <= '0;
			if (last_c_q) begin
				cand_q       <= '0;
				best_score_q <= '0;
				best_cand_q  <= '0;
			end else begin
				cand_q <= cand_q + r2sa_pkg::CAND_W'(1);
				if (score_d > best_score_q) begin
					best_score_q <= score_d;
					best_cand_q  <= cand_q;
				end
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (out_load) out_valid_q <= 1'b1;
		else if (out_ready) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q.score           <= score_d;
			out_q.candidate_index <= cand_q;
			out_q.best_index      <= (score_d > best_score_q) ? cand_q : best_cand_q;
			out_q.scan_done       <= last_c_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// The output only turns valid from the closing step.
	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == r2sa_pkg::ST_DONE))
		else $error("output item appeared outside the closing step");

	// Restoring division keeps the remainder below twice the shifted divisor.
	a_div_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == r2sa_pkg::ST_DIV |-> {4'b0, rem_q} < {dvs_q, 1'b0})
		else $error("division remainder out of range");

	// Within a scan the best score never lies below a score just sent.
	a_best_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) && !out_data.scan_done |-> best_score_q >= out_data.score)
		else $error("best score below emitted score");

	// The end of a scan clears the candidate counter.
	a_scan_clear: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) && out_data.scan_done |-> cand_q == '0)
		else $error("candidate counter not cleared at end of scan");

endmodule

>>> sim/r_squared_split_argmax_top_tb.sv
// Testbench for the weighted R-squared split scorer: directed table, random candidates, scoreboard.
module r_squared_split_argmax_top_tb;

	typedef struct {
		r2sa_pkg::in_item_t  item;
		bit                  typed;
		r2sa_pkg::out_item_t want;
	} stim_row_t;

	logic                            clk;
	logic                            arst_n;
	logic                            in_valid;
	logic                            in_ready;
	r2sa_pkg::in_item_t              in_data;
	logic                            out_valid;
	logic                            out_ready;
	r2sa_pkg::out_item_t             out_data;
	logic                            cfg_valid;
	logic                            cfg_ready;
	logic [r2sa_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [r2sa_pkg::CFG_DATA_W-1:0] cfg_data;

	// Predictor copy of the registers and the scan state.
	logic [r2sa_pkg::WSUM_W-1:0]   weight_sum;
	logic [r2sa_pkg::CNT_W-1:0]    min_side;
	logic [r2sa_pkg::SPREAD_W-1:0] spread [r2sa_pkg::MAX_TARGETS];
	logic [r2sa_pkg::SCORE_W-1:0]  score_acc;
	logic [r2sa_pkg::CAND_W-1:0]   cand_count;
	logic [r2sa_pkg::SCORE_W-1:0]  best_score;
	logic [r2sa_pkg::CAND_W-1:0]   best_cand;

	r2sa_pkg::out_item_t score_queue [$];
	int                  errors;
	int                  send_idle_pct;
	int                  recv_stall_pct;
	int                  hold_left;
	stim_row_t           rows [$];

	r_squared_split_argmax_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Magnitude of a 48-bit two's complement value, widened for the exact arithmetic.
	function automatic logic [255:0] abs_wide(input logic [r2sa_pkg::VAL_W-1:0] v);
		logic [r2sa_pkg::VAL_W-1:0] m;
		m = v[r2sa_pkg::VAL_W-1] ? (~v + 1'b1) : v;
		return {208'd0, m};
	endfunction

	// Adds the weighted R-squared term of one target to the running score, or subtracts it for a negative variance.
	task automatic add_r2_term(input r2sa_pkg::in_item_t it);
		logic [255:0] w, m1, m2, mc, a, b, vr, num, den, syy;
		logic [r2sa_pkg::SCORE_W-1:0] term;
		bit neg;
		w = {216'd0, weight_sum};
		syy = {209'd0, spread[it.target_index]};
		m1 = abs_wide(it.pred_sum);
		m2 = abs_wide(it.pred_square_sum);
		mc = abs_wide(it.cross_sum);
		a = (w * m2) << 8;
		b = m1 * m1;
		if (it.pred_square_sum[r2sa_pkg::VAL_W-1]) begin
			vr = a + b;
			neg = 1'b1;
		end else if (a >= b) begin
			vr = a - b;
			neg = 1'b0;
		end else begin
			vr = b - a;
			neg = 1'b1;
		end
		if (vr == 0 || syy == 0)
			return;
		num = ((mc * mc) * w) << 36;
		den = vr * syy;
		if (num >= (den << 32))
			term = '1;
		else
			term = r2sa_pkg::SCORE_W'(num / den);
		if (!neg)
			score_acc = ({1'b0, score_acc} + term > 33'hFFFFFFFF) ? '1 : score_acc + term;
		else
			score_acc = (score_acc > term) ? score_acc - term : '0;
	endtask

	// Advances the predictor by one item; returns 1 when the item closes a candidate.
	task automatic score_item(input r2sa_pkg::in_item_t it, output bit closes,
			output r2sa_pkg::out_item_t res);
		logic [r2sa_pkg::SCORE_W-1:0] sc;
		add_r2_term(it);
		closes = it.last_target;
		res = '0;
		if (!closes)
			return;
		sc = (it.left_count < min_side || it.right_count < min_side) ? '0 : score_acc;
		if (sc > best_score) begin
			best_score = sc;
			best_cand = cand_count;
		end
		res.score = sc;
		res.candidate_index = cand_count;
		res.best_index = best_cand;
		res.scan_done = it.last_candidate;
		score_acc = '0;
		cand_count = cand_count + r2sa_pkg::CAND_W'(1);
		if (it.last_candidate) begin
			cand_count = '0;
			best_score = '0;
			best_cand = '0;
		end
	endtask

	// One register write; the caller lowers cfg_valid after its last write.
	task automatic write_reg(input logic [r2sa_pkg::CFG_IDX_W-1:0] idx,
			input logic [r2sa_pkg::CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			r2sa_pkg::CFG_WEIGHT_SUM: weight_sum = val[r2sa_pkg::WSUM_W-1:0];
			r2sa_pkg::CFG_MIN_SIDE: min_side = val[r2sa_pkg::CNT_W-1:0];
			default: spread[idx - r2sa_pkg::CFG_TGT_SPREAD_0] = val[r2sa_pkg::SPREAD_W-1:0];
		endcase
	endtask

	task automatic write_all_regs(input logic [r2sa_pkg::WSUM_W-1:0] w,
			input logic [r2sa_pkg::CNT_W-1:0] ms,
			input logic [r2sa_pkg::SPREAD_W-1:0] s0, input logic [r2sa_pkg::SPREAD_W-1:0] s1,
			input logic [r2sa_pkg::SPREAD_W-1:0] s2, input logic [r2sa_pkg::SPREAD_W-1:0] s3);
		write_reg(r2sa_pkg::CFG_WEIGHT_SUM, r2sa_pkg::CFG_DATA_W'(w));
		write_reg(r2sa_pkg::CFG_MIN_SIDE, r2sa_pkg::CFG_DATA_W'(ms));
		write_reg(r2sa_pkg::CFG_TGT_SPREAD_0, s0);
		write_reg(r2sa_pkg::CFG_TGT_SPREAD_1, s1);
		write_reg(r2sa_pkg::CFG_TGT_SPREAD_2, s2);
		write_reg(r2sa_pkg::CFG_TGT_SPREAD_3, s3);
		cfg_valid <= 1'b0;
	endtask

	// Offers one item after a random gap and predicts its result on acceptance.
	task automatic offer_item(input r2sa_pkg::in_item_t it, input bit typed,
			input r2sa_pkg::out_item_t want);
		bit closes;
		r2sa_pkg::out_item_t res;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		score_item(it, closes, res);
		if (closes)
			score_queue.push_back(typed ? want : res);
	endtask

	// Waits until every expected score has arrived and any result-free item has drained.
	task automatic drain;
		in_valid <= 1'b0;
		@(posedge clk);
		while (score_queue.size() != 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	function automatic logic [r2sa_pkg::VAL_W-1:0] rand_value();
		logic signed [r2sa_pkg::VAL_W-1:0] v;
		v = r2sa_pkg::VAL_W'({$urandom, $urandom});
		return v >>> $urandom_range(0, r2sa_pkg::VAL_W - 1);
	endfunction

	function automatic logic [r2sa_pkg::SPREAD_W-1:0] rand_spread();
		logic [r2sa_pkg::SPREAD_W-1:0] v;
		v = r2sa_pkg::SPREAD_W'({$urandom, $urandom});
		return v >> $urandom_range(0, r2sa_pkg::SPREAD_W - 1);
	endfunction

	function automatic r2sa_pkg::in_item_t mk(input logic [r2sa_pkg::VAL_W-1:0] s1,
			input logic [r2sa_pkg::VAL_W-1:0] s2,
			input logic [r2sa_pkg::VAL_W-1:0] c, input int t, input int lc, input int rc,
			input bit lt, input bit lcand);
		r2sa_pkg::in_item_t it;
		it.pred_sum = s1;
		it.pred_square_sum = s2;
		it.cross_sum = c;
		it.target_index = r2sa_pkg::TIX_W'(t);
		it.left_count = r2sa_pkg::CNT_W'(lc);
		it.right_count = r2sa_pkg::CNT_W'(rc);
		it.last_target = lt;
		it.last_candidate = lcand;
		return it;
	endfunction

	function automatic r2sa_pkg::out_item_t res_of(input int cand);
		r2sa_pkg::out_item_t r;
		r = '0;
		r.candidate_index = r2sa_pkg::CAND_W'(cand);
		return r;
	endfunction

	// Scoreboard and receiver stall; a long hold-off is counted down here.
	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			if (score_queue.size() == 0) begin
				$display("%0t: unexpected result %p", $time, out_data);
				errors = errors + 1;
			end else begin
				if (out_data.score !== score_queue[0].score
						|| out_data.candidate_index !== score_queue[0].candidate_index
						|| out_data.best_index !== score_queue[0].best_index
						|| out_data.scan_done !== score_queue[0].scan_done) begin
					$display("%0t: mismatch, expected %p, actual %p", $time,
						score_queue[0], out_data);
					errors = errors + 1;
				end
				void'(score_queue.pop_front());
			end
		end
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Main sequence: reset, registers, directed table, then random phases.
	initial begin
		logic [r2sa_pkg::VAL_W-1:0] vmax, vmin;
		bit lcand;
		int ntg, t;
		int pct_send [4];
		int pct_recv [4];
		vmax = {1'b0, {(r2sa_pkg::VAL_W-1){1'b1}}};
		vmin = {1'b1, {(r2sa_pkg::VAL_W-1){1'b0}}};
		pct_send = '{0, 68, 0, 33};
		pct_recv = '{0, 0, 68, 33};
		errors = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_left = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_ready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		weight_sum = '0;
		min_side = r2sa_pkg::CNT_W'(1);
		for (int i = 0; i < r2sa_pkg::MAX_TARGETS; i++)
			spread[i] = '0;
		score_acc = '0;
		cand_count = '0;
		best_score = '0;
		best_cand = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Target 3 has no spread, so its items add nothing.
		write_all_regs(40'h1_0000, 24'd1, 47'h100_0000, '1, 47'd1, '0);

		// Skipped targets, extreme fields and too few samples all score zero.
		rows.push_back('{mk(vmax, vmax, vmax, 3, 1, 1, 1, 0), 1, res_of(0)});
		rows.push_back('{mk(vmin, vmin, vmin, 3, 24'hFFFFFF, 24'hFFFFFF, 1, 0), 1, res_of(1)});
		rows.push_back('{mk(48'h100_0000, 48'h200_0000, vmax, 0, 0, 5, 1, 0), 1, res_of(2)});
		rows.push_back('{mk(48'h100_0000, 48'h200_0000, vmax, 0, 5, 0, 1, 0), 1, res_of(3)});
		// Zero variance adds nothing.
		rows.push_back('{mk('0, '0, vmax, 0, 1, 1, 1, 0), 1, res_of(4)});
		// A non-closing item ignores its end-of-scan bit.
		rows.push_back('{mk(48'h100_0000, 48'h200_0000, 48'h80_0000, 0, 0, 0, 0, 1), 0, '0});
		rows.push_back('{mk(48'h10_0000, 48'h300_0000, 48'h40_0000, 1, 2, 2, 1, 0), 0, '0});
		// Negative variance terms, most negative inputs, tie on equal scores.
		rows.push_back('{mk(48'h100_0000, vmin, 48'h100_0000, 2, 1, 1, 1, 0), 0, '0});
		rows.push_back('{mk(vmin, vmin, vmin, 0, 1, 1, 1, 0), 0, '0});
		rows.push_back('{mk(vmax, 48'h1, 48'h1000, 0, 1, 1, 1, 0), 0, '0});
		rows.push_back('{mk(48'h100_0000, 48'h200_0000, 48'h80_0000, 0, 1, 1, 1, 0), 0, '0});
		rows.push_back('{mk(48'h100_0000, 48'h200_0000, 48'h80_0000, 0, 1, 1, 1, 0), 0, '0});
		rows.push_back('{mk(48'h10_0000, vmax, vmax, 1, 1, 1, 0, 0), 0, '0});
		rows.push_back('{mk(48'h10_0000, 48'h200_0000, vmax, 0, 1, 1, 1, 1), 0, '0});
		rows.push_back('{mk('0, 48'h100, 48'h10, 2, 1, 1, 1, 1), 0, '0});
		foreach (rows[i])
			offer_item(rows[i].item, rows[i].typed, rows[i].want);
		drain();

		// Random phases, each with its own register setting and idling.
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: write_all_regs('1, '0, '1, '1, '1, '1);
				1: write_all_regs(40'($urandom_range(1, 32'h100_0000)),
					r2sa_pkg::CNT_W'($urandom_range(0, 3)),
					rand_spread(), rand_spread(), rand_spread(), rand_spread());
				2: write_all_regs(40'd1, '1, 47'd1, rand_spread(), '1, rand_spread());
				default: write_all_regs(40'({$urandom, $urandom}),
					r2sa_pkg::CNT_W'($urandom_range(0, 2)),
					rand_spread(), rand_spread(), rand_spread(), '0);
			endcase
			send_idle_pct = pct_send[ph];
			recv_stall_pct = pct_recv[ph];
			if (ph == 1)
				hold_left = 3000;
			for (int n = 0; n < 100; ) begin
				ntg = $urandom_range(1, r2sa_pkg::MAX_TARGETS);
				lcand = ($urandom_range(7) == 0);
				for (int k = 0; k < ntg; k++) begin
					t = ($urandom_range(9) == 0) ? $urandom_range(0, r2sa_pkg::MAX_TARGETS - 1) : k;
					offer_item(mk(rand_value(),
						($urandom_range(4) == 0) ? rand_value() : (rand_value() >> 1),
						rand_value(), t,
						($urandom_range(9) == 0) ? $urandom : $urandom_range(0, 4),
						($urandom_range(9) == 0) ? $urandom : $urandom_range(0, 4),
						k == ntg - 1, (k == ntg - 1) ? lcand : ($urandom_range(1) == 1)),
						0, '0);
					n = n + 1;
				end
				// In phase 2 the sender pauses until every score is back, after each candidate that leaves n between 51 and 54.
				if (ph == 2 && n > 50 && n < 55) begin
					in_valid <= 1'b0;
					@(posedge clk);
					while (score_queue.size() != 0)
						@(posedge clk);
				end
			end
			drain();
		end

		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	initial begin
		repeat (2000000) @(posedge clk);
		$display("CHECK FAILED");
		$finish;
	end

endmodule
